// ----- hw/rtl/adrp_pkg.sv -----
// Shared types, constants and codes of the archive directory record parser.
package adrp_pkg;

    localparam int unsigned MAX_RECORDS   = 65536;
    localparam int unsigned MAX_DIRECTORY = 4194304;

    localparam int unsigned FIXED_PART = 17;
    localparam int unsigned MIN_NAME   = 2;
    localparam int unsigned MIN_STREAM = 14;
    localparam int unsigned MIN_FIRST  = 64;
    localparam int unsigned LOW_CHAR   = 32;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_TRUNC  = 3'd1;
    localparam logic [2:0] ST_NAME   = 3'd2;
    localparam logic [2:0] ST_CTRL   = 3'd3;
    localparam logic [2:0] ST_FIRST  = 3'd4;
    localparam logic [2:0] ST_GAP    = 3'd5;
    localparam logic [2:0] ST_RANGE  = 3'd6;
    localparam logic [2:0] ST_END    = 3'd7;

    localparam logic [1:0] CFG_RECORD_COUNT    = 2'd0;
    localparam logic [1:0] CFG_DIRECTORY_START = 2'd1;
    localparam logic [1:0] CFG_DIRECTORY_BYTES = 2'd2;

    typedef struct packed {
        logic [16:0] record_count;
        logic [31:0] directory_start;
        logic [22:0] directory_bytes;
    } t_config;

    // One record end or early stop, as the front part classified it.
    typedef struct packed {
        logic [15:0] record_number;
        logic [31:0] stream_offset;
        logic [31:0] comp_size;
        logic [31:0] raw_size;
        logic [31:0] byte_sum;
        logic [7:0]  name_length;
        logic [2:0]  status;
        logic        check;       // record passed front checks, back must finish it
        logic        first;
        logic        last;
        logic        pk_bad;
        logic        pos_bad;
        logic [32:0] stream_end;
    } t_event;

    typedef struct packed {
        logic [15:0] record_number;
        logic [31:0] stream_offset;
        logic [31:0] comp_size;
        logic [31:0] raw_size;
        logic [31:0] byte_sum;
        logic [7:0]  name_length;
        logic [47:0] raw_total;
        logic [2:0]  status;
        logic        last_record;
    } t_result;

endpackage

// ----- hw/rtl/archive_directory_record_parser.sv -----
// Top level: configuration registers, front part, event queue and back part.
// Throughput: one byte per cycle unless full; full rises only while two events wait.
// Path: the edge that takes a record's last byte writes its event to the event queue;
// the back part then writes its result to the result queue once that queue has room.
// Reset: synchronous, active low; clears all counters, queues and both stop flags,
// and loads record_count 1, directory_start 78, directory_bytes 19.
module archive_directory_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_dir_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_record_number,
    output logic [31:0] o_stream_offset,
    output logic [31:0] o_comp_size,
    output logic [31:0] o_raw_size,
    output logic [31:0] o_byte_sum,
    output logic [7:0]  o_name_length,
    output logic [47:0] o_raw_total,
    output logic [2:0]  o_status,
    output logic        o_last_record,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    adrp_pkg::t_config r_cfg;
    adrp_pkg::t_event  fe_ev;
    adrp_pkg::t_event  q_ev;
    adrp_pkg::t_result res;
    logic              fe_push;
    logic              q_valid;
    logic              q_full;
    logic              q_pop;
    logic              in_beat;

    assign in_beat = push && !q_full;
    assign full    = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_count    <= 17'd1;
            r_cfg.directory_start <= 32'd78;
            r_cfg.directory_bytes <= 23'd19;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                adrp_pkg::CFG_RECORD_COUNT:    r_cfg.record_count    <= i_cfg_data[16:0];
                adrp_pkg::CFG_DIRECTORY_START: r_cfg.directory_start <= i_cfg_data;
                adrp_pkg::CFG_DIRECTORY_BYTES: r_cfg.directory_bytes <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    adrp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (in_beat),
        .i_dir_byte (i_dir_byte),
        .o_ev_push  (fe_push),
        .o_ev       (fe_ev)
    );

    adrp_event_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_ev    (fe_ev),
        .i_pop   (q_pop),
        .o_ev    (q_ev),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    adrp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_directory_start (r_cfg.directory_start),
        .i_ev_valid        (q_valid),
        .i_ev              (q_ev),
        .o_ev_pop          (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_result          (res)
    );

    assign o_record_number  = res.record_number;
    assign o_stream_offset  = res.stream_offset;
    assign o_comp_size      = res.comp_size;
    assign o_raw_size       = res.raw_size;
    assign o_byte_sum       = res.byte_sum;
    assign o_name_length    = res.name_length;
    assign o_raw_total      = res.raw_total;
    assign o_status         = res.status;
    assign o_last_record    = res.last_record;

    a_pop_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("event popped from empty queue");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_push |-> !q_full)
        else $error("front pushed an event into a full queue");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != adrp_pkg::ST_OK) |-> o_last_record)
        else $error("error result not marked last");

    a_nothing_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_record) |=> empty)
        else $error("result queued after the final result");

endmodule

// ----- hw/rtl/adrp_front.sv -----
// Front part: takes directory bytes, assembles record fields and classifies record ends.
module adrp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adrp_pkg::t_config   i_cfg,
    input  logic                i_valid,
    input  logic [7:0]          i_dir_byte,
    output logic                o_ev_push,
    output adrp_pkg::t_event    o_ev
);

    logic [8:0]  r_k,     n_k;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_off,   n_off;
    logic [31:0] r_pk,    n_pk;
    logic [31:0] r_unp,   n_unp;
    logic [31:0] r_sum,   n_sum;
    logic [7:0]  r_nl,    n_nl;
    logic        r_ctrl,  n_ctrl;
    logic [22:0] r_pos,   n_pos;
    logic [16:0] r_idx,   n_idx;
    logic        r_done,  n_done;

    logic [16:0] count_sat;
    logic [22:0] size_sat;
    logic [23:0] size_x;
    logic [23:0] pos_x;
    logic [23:0] pos1;
    logic [23:0] remaining;
    logic [23:0] left_after;
    logic        trunc;
    logic        last;
    logic        pk_bad;
    logic        name_more;
    logic [31:0] shift_n;

    assign count_sat  = i_cfg.record_count[16] ? 17'(adrp_pkg::MAX_RECORDS)
                                               : i_cfg.record_count;
    assign size_sat   = (i_cfg.directory_bytes > 23'(adrp_pkg::MAX_DIRECTORY))
                        ? 23'(adrp_pkg::MAX_DIRECTORY) : i_cfg.directory_bytes;
    assign size_x     = {1'b0, size_sat};
    assign pos_x      = {1'b0, r_pos};
    assign pos1       = pos_x + 24'd1;
    assign remaining  = (size_x > pos_x) ? size_x - pos_x : 24'd0;
    assign left_after = (size_x > pos1) ? size_x - pos1 : 24'd0;
    assign trunc      = remaining < 24'(adrp_pkg::FIXED_PART + adrp_pkg::MIN_NAME);
    assign last       = ({1'b0, r_idx} + 18'd1) >= {1'b0, count_sat};
    // offset past the start short-circuits the wrapped difference
    assign pk_bad     = (r_pk < 32'(adrp_pkg::MIN_STREAM))
                     || (r_off > i_cfg.directory_start)
                     || (r_pk > (i_cfg.directory_start - r_off));
    assign name_more  = r_k < ({1'b0, r_nl} + 9'(adrp_pkg::FIXED_PART - 1));
    assign shift_n    = {i_dir_byte, r_shift[31:8]};

    always_comb begin
        n_k     = r_k;
        n_shift = r_shift;
        n_off   = r_off;
        n_pk    = r_pk;
        n_unp   = r_unp;
        n_sum   = r_sum;
        n_nl    = r_nl;
        n_ctrl  = r_ctrl;
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_done  = r_done;

        o_ev_push           = 1'b0;
        o_ev.record_number  = r_idx[15:0];
        o_ev.stream_offset  = r_off;
        o_ev.comp_size      = r_pk;
        o_ev.raw_size       = r_unp;
        o_ev.byte_sum       = r_sum;
        o_ev.name_length    = r_nl;
        o_ev.status         = adrp_pkg::ST_OK;
        o_ev.check          = 1'b0;
        o_ev.first          = (r_idx == 17'd0);
        o_ev.last           = last;
        o_ev.pk_bad         = pk_bad;
        o_ev.pos_bad        = (pos1 != size_x);
        o_ev.stream_end     = {1'b0, r_off} + {1'b0, r_pk};

        if (i_valid && !r_done) begin
            if (count_sat == 17'd0 || (r_k == 9'd0 && trunc)) begin
                o_ev_push          = 1'b1;
                o_ev.stream_offset = '0;
                o_ev.comp_size     = '0;
                o_ev.raw_size      = '0;
                o_ev.byte_sum      = '0;
                o_ev.name_length   = '0;
                o_ev.status        = (count_sat == 17'd0) ? adrp_pkg::ST_END
                                                          : adrp_pkg::ST_TRUNC;
                o_ev.last          = 1'b1;
                n_done             = 1'b1;
            end else begin
                if (r_k == 9'd0) begin
                    n_ctrl = 1'b0;
                end
                n_shift = shift_n;
                case (r_k)
                    9'd3:    n_off = shift_n;
                    9'd7:    n_pk  = shift_n;
                    9'd11:   n_unp = shift_n;
                    9'd15:   n_sum = shift_n;
                    default: ;
                endcase
                n_pos = pos1[22:0];
                n_k   = r_k + 9'd1;

                if (r_k == 9'(adrp_pkg::FIXED_PART - 1)) begin
                    n_nl = i_dir_byte;
                    if (i_dir_byte < 8'(adrp_pkg::MIN_NAME)
                        || left_after < {16'd0, i_dir_byte}) begin
                        o_ev_push        = 1'b1;
                        o_ev.name_length = i_dir_byte;
                        o_ev.status      = adrp_pkg::ST_NAME;
                        o_ev.last        = 1'b1;
                        n_done           = 1'b1;
                    end
                end else if (r_k >= 9'(adrp_pkg::FIXED_PART)) begin
                    if (name_more) begin
                        if (i_dir_byte < 8'(adrp_pkg::LOW_CHAR)) begin
                            n_ctrl = 1'b1;
                        end
                    end else begin
                        // terminator byte closes the record
                        o_ev_push = 1'b1;
                        if (i_dir_byte != 8'd0) begin
                            o_ev.status = adrp_pkg::ST_NAME;
                            o_ev.last   = 1'b1;
                            n_done      = 1'b1;
                        end else if (r_ctrl) begin
                            o_ev.status = adrp_pkg::ST_CTRL;
                            o_ev.last   = 1'b1;
                            n_done      = 1'b1;
                        end else if (r_idx == 17'd0 && r_off < 32'(adrp_pkg::MIN_FIRST)) begin
                            o_ev.status = adrp_pkg::ST_FIRST;
                            o_ev.last   = 1'b1;
                            n_done      = 1'b1;
                        end else begin
                            o_ev.check = 1'b1;
                            if (last) begin
                                n_done = 1'b1;
                            end else begin
                                n_idx = r_idx + 17'd1;
                                n_k   = 9'd0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_ctrl <= 1'b0;
            r_pos  <= '0;
            r_idx  <= '0;
            r_done <= 1'b0;
        end else begin
            r_k    <= n_k;
            r_ctrl <= n_ctrl;
            r_pos  <= n_pos;
            r_idx  <= n_idx;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_off   <= n_off;
        r_pk    <= n_pk;
        r_unp   <= n_unp;
        r_sum   <= n_sum;
        r_nl    <= n_nl;
    end

endmodule

// ----- hw/rtl/adrp_event_queue.sv -----
// Two-entry queue of classified record events between front and back parts.
module adrp_event_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  adrp_pkg::t_event    i_ev,
    input  logic                i_pop,
    output adrp_pkg::t_event    o_ev,
    output logic                o_valid,
    output logic                o_full
);

    adrp_pkg::t_event r_mem [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_ev    = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_ev;
        end
    end

endmodule

// ----- hw/rtl/adrp_back.sv -----
// Back part: cross-record checks, running total and the result queue.
module adrp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_directory_start,
    input  logic                i_ev_valid,
    input  adrp_pkg::t_event    i_ev,
    output logic                o_ev_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output adrp_pkg::t_result   o_result
);

    adrp_pkg::t_result r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic [32:0]       r_next, n_next;
    logic [47:0]       r_total, n_total;
    logic              r_done, n_done;

    adrp_pkg::t_result res;
    logic              res_push;
    logic              out_pop;
    logic [47:0]       sum;

    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_mem[r_rp];
    assign out_pop  = i_pop && !o_empty;
    // once stopped, leftover events are drained and dropped
    assign o_ev_pop = i_ev_valid && (r_done || r_cnt != 2'd2);
    assign sum      = r_total + {16'd0, i_ev.raw_size};

    always_comb begin
        n_next   = r_next;
        n_total  = r_total;
        n_done   = r_done;
        res_push = 1'b0;

        res.record_number  = i_ev.record_number;
        res.stream_offset  = i_ev.stream_offset;
        res.comp_size      = i_ev.comp_size;
        res.raw_size       = i_ev.raw_size;
        res.byte_sum       = i_ev.byte_sum;
        res.name_length    = i_ev.name_length;
        res.raw_total      = r_total;
        res.status         = i_ev.status;
        res.last_record    = i_ev.last;

        if (i_ev.check) begin
            if (!i_ev.first && {1'b0, i_ev.stream_offset} != r_next) begin
                res.status      = adrp_pkg::ST_GAP;
                res.last_record = 1'b1;
            end else if (i_ev.pk_bad) begin
                res.status      = adrp_pkg::ST_RANGE;
                res.last_record = 1'b1;
            end else begin
                res.raw_total = sum;
                if (i_ev.last && (i_ev.pos_bad
                    || i_ev.stream_end != {1'b0, i_directory_start})) begin
                    res.status = adrp_pkg::ST_END;
                end
            end
        end

        if (o_ev_pop && !r_done) begin
            res_push = 1'b1;
            if (res.last_record) begin
                n_done = 1'b1;
            end
            if (i_ev.check && res.status != adrp_pkg::ST_GAP
                && res.status != adrp_pkg::ST_RANGE) begin
                n_next  = i_ev.stream_end;
                n_total = sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
            r_next  <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_wp    <= res_push ? ~r_wp : r_wp;
            r_rp    <= out_pop  ? ~r_rp : r_rp;
            r_cnt   <= r_cnt + {1'b0, res_push} - {1'b0, out_pop};
            r_next  <= n_next;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_mem[r_wp] <= res;
        end
    end

endmodule

// ----- bench/tb_archive_directory_record_parser.sv -----
// Testbench for the archive directory record parser: byte stimulus with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_archive_directory_record_parser;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned ITEM_TARGET = 1380;
    localparam int unsigned QUIET_AFTER = 1200;
    localparam longint unsigned PACK_RESERVE = 64'h10_0000;

    typedef enum {
        END_CLEAN, END_SIZE_MISMATCH, END_STREAM_MISMATCH, END_NO_RECORDS, END_TRUNCATED,
        END_SHORT_NAME, END_LONG_NAME, END_BAD_TERMINATOR, END_CONTROL_CHAR, END_GAP,
        END_SMALL_PACKED, END_PAST_START, END_OVER_START, END_LOW_FIRST
    } t_ending;

    // Mirrors the parser state, predicts one result per finished or failed record.
    class record_predictor;
        logic [16:0] rec_count_reg;
        logic [31:0] dir_start_reg;
        logic [22:0] dir_bytes_reg;
        logic [8:0]  rec_byte;
        logic [31:0] shift;
        logic [31:0] off_w, pk_w, unp_w, sum_w;
        logic [7:0]  name_len;
        bit          ctrl_seen;
        logic [32:0] chain_end;
        logic [22:0] pos;
        logic [16:0] rec_idx;
        logic [47:0] total;
        bit          stopped;
        logic [2:0]  end_status;
        int          errors;
        int          checked;
        adrp_pkg::t_result expected_records[$];

        function new();
            rec_count_reg = 17'd1;
            dir_start_reg = 32'd78;
            dir_bytes_reg = 23'd19;
            rec_byte = '0;
            shift = '0;
            off_w = '0;
            pk_w = '0;
            unp_w = '0;
            sum_w = '0;
            name_len = '0;
            ctrl_seen = 0;
            chain_end = '0;
            pos = '0;
            rec_idx = '0;
            total = '0;
            stopped = 0;
            end_status = adrp_pkg::ST_OK;
            errors = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                adrp_pkg::CFG_RECORD_COUNT:    rec_count_reg = val[16:0];
                adrp_pkg::CFG_DIRECTORY_START: dir_start_reg = val;
                adrp_pkg::CFG_DIRECTORY_BYTES: dir_bytes_reg = val[22:0];
                default: ;
            endcase
        endfunction

        function void post(bit zero, logic [2:0] st, bit last);
            adrp_pkg::t_result r;
            r.record_number  = rec_idx[15:0];
            r.stream_offset  = zero ? '0 : off_w;
            r.comp_size      = zero ? '0 : pk_w;
            r.raw_size       = zero ? '0 : unp_w;
            r.byte_sum       = zero ? '0 : sum_w;
            r.name_length    = zero ? '0 : name_len;
            r.raw_total      = total;
            r.status         = st;
            r.last_record    = last;
            end_status = st;
            expected_records.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned cnt, size, p, k, left_after, remaining, j;
            longint unsigned off, pk, start;
            logic [2:0] st;
            bit last;
            if (stopped) return;
            cnt  = (32'(rec_count_reg) > adrp_pkg::MAX_RECORDS) ? adrp_pkg::MAX_RECORDS
                                                               : 32'(rec_count_reg);
            size = (32'(dir_bytes_reg) > adrp_pkg::MAX_DIRECTORY) ? adrp_pkg::MAX_DIRECTORY
                                                                 : 32'(dir_bytes_reg);
            p = 32'(pos);
            k = 32'(rec_byte);
            left_after = (size > p + 1) ? size - (p + 1) : 0;
            if (cnt == 0) begin
                stopped = 1;
                post(1'b1, adrp_pkg::ST_END, 1'b1);
                return;
            end
            if (k == 0) begin
                remaining = (size > p) ? size - p : 0;
                if (remaining < adrp_pkg::FIXED_PART + adrp_pkg::MIN_NAME) begin
                    stopped = 1;
                    post(1'b1, adrp_pkg::ST_TRUNC, 1'b1);
                    return;
                end
                ctrl_seen = 0;
            end
            // words arrive little-endian, so each byte enters at the top
            shift = {b, shift[31:8]};
            case (k)
                3:  off_w = shift;
                7:  pk_w  = shift;
                11: unp_w = shift;
                15: sum_w = shift;
                default: ;
            endcase
            pos = 23'(p + 1);
            rec_byte = 9'(k + 1);
            if (k == 16) begin
                name_len = b;
                if (b < adrp_pkg::MIN_NAME || left_after < b) begin
                    stopped = 1;
                    post(1'b0, adrp_pkg::ST_NAME, 1'b1);
                end
                return;
            end
            if (k < 16) return;
            j = k - adrp_pkg::FIXED_PART;
            if (j + 1 < name_len) begin
                if (b < adrp_pkg::LOW_CHAR) ctrl_seen = 1;
                return;
            end
            // terminator byte closes the record
            last = (rec_idx + 1 >= cnt);
            off = 64'(off_w);
            pk = 64'(pk_w);
            start = 64'(dir_start_reg);
            st = adrp_pkg::ST_OK;
            if (b != 0) st = adrp_pkg::ST_NAME;
            else if (ctrl_seen) st = adrp_pkg::ST_CTRL;
            else if (rec_idx == 0 && off < adrp_pkg::MIN_FIRST) st = adrp_pkg::ST_FIRST;
            else if (rec_idx != 0 && off != chain_end) st = adrp_pkg::ST_GAP;
            else if (pk < adrp_pkg::MIN_STREAM || off > start || pk > start - off)
                st = adrp_pkg::ST_RANGE;
            if (st != adrp_pkg::ST_OK) begin
                stopped = 1;
                post(1'b0, st, 1'b1);
                return;
            end
            chain_end = 33'(off + pk);
            total = total + 48'(unp_w);
            if (last) begin
                if (p + 1 != size || chain_end != start) st = adrp_pkg::ST_END;
                stopped = 1;
                post(1'b0, st, 1'b1);
                return;
            end
            post(1'b0, adrp_pkg::ST_OK, 1'b0);
            rec_idx = 17'(rec_idx + 1);
            rec_byte = '0;
        endfunction

        function void compare_field(string field, logic [47:0] want, logic [47:0] got);
            if (got !== want) begin
                $error("%s: expected %0h actual %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(adrp_pkg::t_result got);
            adrp_pkg::t_result want;
            if (expected_records.size() == 0) begin
                $error("result with none pending: record %0d status %0d",
                       got.record_number, got.status);
                errors++;
                return;
            end
            want = expected_records.pop_front();
            checked++;
            compare_field("record_number", 48'(want.record_number), 48'(got.record_number));
            compare_field("stream_offset", 48'(want.stream_offset), 48'(got.stream_offset));
            compare_field("comp_size", 48'(want.comp_size), 48'(got.comp_size));
            compare_field("raw_size", 48'(want.raw_size), 48'(got.raw_size));
            compare_field("byte_sum", 48'(want.byte_sum), 48'(got.byte_sum));
            compare_field("name_length", 48'(want.name_length), 48'(got.name_length));
            compare_field("raw_total", want.raw_total, got.raw_total);
            compare_field("status", 48'(want.status), 48'(got.status));
            compare_field("last_record", 48'(want.last_record), 48'(got.last_record));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  dir_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_record_number;
    logic [31:0] o_stream_offset;
    logic [31:0] o_comp_size;
    logic [31:0] o_raw_size;
    logic [31:0] o_byte_sum;
    logic [7:0]  o_name_length;
    logic [47:0] o_raw_total;
    logic [2:0]  o_status;
    logic        o_last_record;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    record_predictor board = new();
    bit          quiet = 0;
    bit          tx_jitter = 1;
    bit          rx_jitter = 1;
    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;

    archive_directory_record_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_dir_byte       (dir_byte),
        .empty            (empty),
        .pop              (pop),
        .o_record_number  (o_record_number),
        .o_stream_offset  (o_stream_offset),
        .o_comp_size      (o_comp_size),
        .o_raw_size       (o_raw_size),
        .o_byte_sum       (o_byte_sum),
        .o_name_length    (o_name_length),
        .o_raw_total      (o_raw_total),
        .o_status         (o_status),
        .o_last_record    (o_last_record),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("archive_directory_record_parser test failed");
            $finish;
        end
    end

    // result side: random stall bursts on pop
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else if (!quiet && rx_jitter && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                hold = $urandom_range(1, 17) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_result({o_record_number, o_stream_offset, o_comp_size,
                                o_raw_size, o_byte_sum, o_name_length,
                                o_raw_total, o_status, o_last_record});
        end
    end

    // Entered at a falling edge; leaves push high so back-to-back beats need no gap.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && tx_jitter && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        push <= 1'b1;
        dir_byte <= b;
        do @(posedge i_clk); while (full);
        board.take_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_record(input logic [31:0] off, input logic [31:0] pk,
                               input logic [31:0] unp, input logic [31:0] sum,
                               input logic [7:0] nlen, input int ctrl_at,
                               input logic [7:0] term);
        logic [127:0] words;
        words = {sum, unp, pk, off};
        for (int i = 0; i < 16; i++) send_byte(words[8*i +: 8]);
        send_byte(nlen);
        if (board.stopped) return;
        for (int i = 0; i + 1 < nlen; i++) begin
            send_byte(i == ctrl_at ? 8'($urandom_range(0, adrp_pkg::LOW_CHAR - 1))
                                   : 8'($urandom_range(adrp_pkg::LOW_CHAR, 255)));
        end
        send_byte(term);
    endtask

    // stop sending, let every pending result out, then cover the pipeline latency
    task automatic settle();
        push <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] cnt, input logic [31:0] start,
                               input logic [31:0] bytes);
        i_cfg_we <= 1'b1;
        i_cfg_index <= adrp_pkg::CFG_RECORD_COUNT;
        i_cfg_data <= cnt;
        @(negedge i_clk);
        board.set_reg(adrp_pkg::CFG_RECORD_COUNT, cnt);
        i_cfg_index <= adrp_pkg::CFG_DIRECTORY_START;
        i_cfg_data <= start;
        @(negedge i_clk);
        board.set_reg(adrp_pkg::CFG_DIRECTORY_START, start);
        i_cfg_index <= adrp_pkg::CFG_DIRECTORY_BYTES;
        i_cfg_data <= bytes;
        @(negedge i_clk);
        board.set_reg(adrp_pkg::CFG_DIRECTORY_BYTES, bytes);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 17) return 8'($urandom_range(2, 16));
        if (r == 17) return 8'd255;
        return 8'($urandom_range(17, 255));
    endfunction

    // Mostly short streams, now and then a big one so offsets climb into the high bits.
    function automatic logic [31:0] pick_packed(logic [31:0] off);
        longint unsigned room, cap, top;
        int unsigned r;
        room = board.dir_start_reg - off;
        r = $urandom_range(0, 19);
        cap = (r < 14) ? 4096 : (r < 19) ? room / 64 : room / 4;
        if (room > PACK_RESERVE + 14) top = (cap < room - PACK_RESERVE) ? cap : room - PACK_RESERVE;
        else top = 14;
        if (top < 14) top = 14;
        return $urandom_range(14, 32'(top));
    endfunction

    // Settings change only at a record boundary with nothing in flight.
    task automatic new_phase();
        logic [31:0] cnt, start, bytes;
        longint unsigned floor_start;
        settle();
        case ($urandom_range(0, 3))
            0: cnt = 32'h1FFFF;
            1: cnt = adrp_pkg::MAX_RECORDS;
            2: cnt = 32'hFFFF_FFFF;
            default: cnt = $urandom_range(board.rec_idx + 200, adrp_pkg::MAX_RECORDS);
        endcase
        case ($urandom_range(0, 3))
            0: bytes = 32'h7FFFFF;
            1: bytes = adrp_pkg::MAX_DIRECTORY;
            2: bytes = 32'hFFFF_FFFF;
            default: bytes = $urandom_range(board.pos + 4000, adrp_pkg::MAX_DIRECTORY);
        endcase
        floor_start = board.chain_end + 64'h100_0000;
        if ($urandom_range(0, 1) == 0 || floor_start > 64'hFFFF_FFFF) start = '1;
        else start = $urandom_range(32'(floor_start), 32'hFFFF_FFFF);
        load_config(cnt, start, bytes);
        tx_jitter = ($urandom_range(0, 3) != 0);
        rx_jitter = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        t_ending ending;
        logic [31:0] off, pk;
        logic [7:0] nlen, term;
        int ctrl_at, m, len, phase_left;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        load_config(32'h1FFFF, 32'hFFFF_FFFF, 32'h7FFFFF);

        if ($urandom_range(0, 15) == 0) ending = END_LOW_FIRST;
        else ending = t_ending'($urandom_range(0, int'(END_OVER_START)));

        if (ending == END_LOW_FIRST) begin
            // only the first record checks its offset against the floor
            send_record($urandom_range(0, adrp_pkg::MIN_FIRST - 1), $urandom_range(14, 4096),
                        rand_word(), rand_word(), pick_name_len(), -1, 8'h00);
        end else begin
            // boundary record: lowest first offset, shortest stream and name
            send_record(adrp_pkg::MIN_FIRST, adrp_pkg::MIN_STREAM, 32'hFFFF_FFFF, 32'h0,
                        8'(adrp_pkg::MIN_NAME), -1, 8'h00);
            off = board.chain_end[31:0];
            send_record(off, pick_packed(off), 32'h0, 32'hFFFF_FFFF, 8'd3, -1, 8'h00);

            phase_left = $urandom_range(5, 12);
            while (bytes_sent < ITEM_TARGET || board.rec_idx < 20) begin
                if (phase_left == 0) begin
                    new_phase();
                    phase_left = $urandom_range(5, 12);
                end
                phase_left--;
                if (bytes_sent >= QUIET_AFTER) quiet = 1;
                off = board.chain_end[31:0];
                send_record(off, pick_packed(off), rand_word(), rand_word(),
                            pick_name_len(), -1, 8'h00);
            end

            quiet = 1;
            settle();
            off = board.chain_end[31:0];
            pk = $urandom_range(14, 4096);
            nlen = 8'($urandom_range(2, 16));
            term = 8'h00;
            ctrl_at = -1;
            case (ending)
                END_CLEAN, END_SIZE_MISMATCH, END_STREAM_MISMATCH: begin
                    len = 17 + nlen;
                    load_config(board.rec_idx + 1,
                                off + pk + (ending == END_STREAM_MISMATCH ?
                                            $urandom_range(1, 1000) : 0),
                                board.pos + len + (ending == END_SIZE_MISMATCH ?
                                                   $urandom_range(1, 3) : 0));
                end
                END_NO_RECORDS:
                    load_config(32'h0, board.dir_start_reg, 32'(board.dir_bytes_reg));
                END_TRUNCATED:
                    load_config(32'(board.rec_count_reg), board.dir_start_reg,
                                board.pos + $urandom_range(0, 18));
                END_SHORT_NAME:
                    nlen = 8'($urandom_range(0, adrp_pkg::MIN_NAME - 1));
                END_LONG_NAME: begin
                    // length byte larger than what the directory still holds
                    m = $urandom_range(0, 200);
                    load_config(32'(board.rec_count_reg), board.dir_start_reg,
                                board.pos + 19 + m);
                    nlen = 8'($urandom_range(m + 3, 255));
                end
                END_BAD_TERMINATOR:
                    term = 8'($urandom_range(1, 255));
                END_CONTROL_CHAR: begin
                    nlen = 8'($urandom_range(3, 40));
                    ctrl_at = $urandom_range(0, nlen - 2);
                end
                END_GAP:
                    off = off ^ (32'h1 << $urandom_range(0, 31));
                END_SMALL_PACKED:
                    pk = $urandom_range(0, adrp_pkg::MIN_STREAM - 1);
                END_PAST_START:
                    load_config(32'(board.rec_count_reg), off - $urandom_range(1, 64),
                                32'(board.dir_bytes_reg));
                END_OVER_START:
                    pk = board.dir_start_reg - off + 1 + $urandom_range(0, 63);
                default: ;
            endcase
            if (ending == END_NO_RECORDS || ending == END_TRUNCATED) send_byte(8'($urandom));
            else send_record(off, pk, rand_word(), rand_word(), nlen, ctrl_at, term);
        end

        // parser has stopped: these beats must produce nothing
        quiet = 1;
        for (int i = 0; i < 20; i++) send_byte(8'($urandom));
        settle();

        $display("Run covered %0d directory bytes and %0d checked results, ending %s.",
                 bytes_sent, board.checked, ending.name());
        $display("Closing status %0d, %0d mismatches.", board.end_status, board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("archive_directory_record_parser test passed");
        end else begin
            $display("archive_directory_record_parser test failed");
        end
        $finish;
    end

endmodule
